@@ design/rtrt_pkg.sv @@
// Package: shared types and codes for the request timeout retry table.
package rtrt_pkg;

	typedef enum logic [1:0] {
		ACT_SEND  = 2'd0,
		ACT_REPLY = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_CLOSE = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		K_TRANSMIT = 4'd0,
		K_FULL     = 4'd1,
		K_DONE     = 4'd2,
		K_FAILED   = 4'd3,
		K_IGNORED  = 4'd4,
		K_RESEND   = 4'd5,
		K_EXPIRED  = 4'd6,
		K_FLUSHED  = 4'd7,
		K_NOTHING  = 4'd8
	} kind_t;

	typedef enum logic [1:0] {
		REG_TIMEOUT = 2'd0,
		REG_MAXRTY  = 2'd1,
		REG_ERRSTAT = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DECIDE,
		ST_EMIT,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] packet_id;
		logic [7:0]  connection;
		logic [3:0]  retry_count;
		logic        last;
	} result_t;

endpackage

@@ design/request_timeout_retry_table.sv @@
// Top level: outstanding request table with timeout, retry and flush.
// Each transaction walks the table one entry at a time through a single
// registered read port: each entry passes a read state and a decide state,
// and a tick adds an evaluate state per entry for the age compare. Each
// flushed, resent or expired entry adds an emit state. Every result waits
// in the output register until taken, which stalls the walk. Valid bits are
// flip-flops cleared by reset; the entry payload memory needs no clearing.
module request_timeout_retry_table
	import rtrt_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] packet_id, [39:32] connection_id, [43:40] reply_status, [75:44] now, pad
	input  logic [79:0] s_tdata,
	// action
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] out_packet_id, [39:32] out_connection, [43:40] retry_count, pad
	output logic [47:0] m_tdata,
	// kind
	output logic [3:0]  m_tuser,
	output logic        m_tlast
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [31:0] timeout_q;
	logic [3:0]  maxrty_q, errstat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 32'd1000;
			maxrty_q  <= 4'd3;
			errstat_q <= 4'd15;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_MAXRTY:  maxrty_q  <= cfg_data[3:0];
				REG_ERRSTAT: errstat_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// entry memory: pid, conn, expected status, time sent, retries
	logic [31:0] mem_pid [TABLE_DEPTH];
	logic [7:0]  mem_conn [TABLE_DEPTH];
	logic [3:0]  mem_exp [TABLE_DEPTH];
	logic [31:0] mem_time [TABLE_DEPTH];
	logic [3:0]  mem_rty [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;

	state_t      state_q, state_d;
	action_t     act_q;
	logic [31:0] pid_q, now_q;
	logic [7:0]  conn_q;
	logic [3:0]  stat_q;
	logic [CW-1:0] idx_q;
	logic        found_q, free_found_q, phase2_q;
	logic [IW-1:0] slot_q, free_q;
	logic        any_q;

	logic [31:0] rd_pid, rd_time;
	logic [7:0]  rd_conn;
	logic [3:0]  rd_exp, rd_rty;
	logic        rd_valid;
	logic        timed_q;

	result_t     res_q, res_d;
	logic        ovalid_q;

	// walk results are held one back so the final one can carry last
	result_t     hold_q, out_d;
	logic        hold_v_q;
	logic        load_out, push_last;

	logic [IW-1:0] ridx;
	logic        do_read, emit, wr_en, clr_en, set_en;
	logic [IW-1:0] wr_idx;
	logic [31:0] wr_time;
	logic [3:0]  wr_rty;
	logic        wr_full;

	// the final step of a send or reply reads back the matched slot
	assign ridx = (state_q == ST_FINAL) ? slot_q : idx_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (do_read) begin
			rd_pid  <= mem_pid[ridx];
			rd_conn <= mem_conn[ridx];
			rd_exp  <= mem_exp[ridx];
			rd_time <= mem_time[ridx];
			rd_rty  <= mem_rty[ridx];
		end
		if (wr_en) begin
			mem_time[wr_idx] <= wr_time;
			mem_rty[wr_idx]  <= wr_rty;
			if (wr_full) begin
				mem_pid[wr_idx]  <= pid_q;
				mem_conn[wr_idx] <= conn_q;
				mem_exp[wr_idx]  <= stat_q;
			end
		end
	end

	logic        s_acc, last_idx, out_free;
	logic [31:0] age;
	assign s_acc    = s_tvalid && s_tready;
	assign last_idx = (idx_q == CW'(TABLE_DEPTH - 1));
	assign out_free = !ovalid_q || m_tready;
	assign age      = now_q - rd_time;
	assign s_tready = (state_q == ST_IDLE) && !ovalid_q;

	always_comb begin
		state_d = state_q;
		do_read = 1'b0;
		emit    = 1'b0;
		wr_en   = 1'b0;
		wr_full = 1'b0;
		wr_idx  = ridx;
		wr_time = now_q;
		wr_rty  = 4'd0;
		clr_en  = 1'b0;
		set_en  = 1'b0;
		res_d   = '0;
		case (state_q)
			ST_IDLE: if (s_acc) state_d = ST_READ;
			ST_READ: begin
				do_read = 1'b1;
				state_d = (act_q == ACT_TICK) ? ST_EVAL : ST_DECIDE;
			end
			ST_EVAL: state_d = ST_DECIDE;
			ST_DECIDE: begin
				state_d = ST_READ;
				case (act_q)
					ACT_SEND, ACT_REPLY: begin
						if (last_idx) state_d = ST_FINAL;
					end
					ACT_TICK: begin
						if (rd_valid && timed_q) begin
							state_d = ST_EMIT;
						end else if (last_idx) state_d = ST_FINAL;
					end
					default: begin
						if (rd_valid && rd_conn == conn_q) state_d = ST_EMIT;
						else if (last_idx) state_d = ST_FINAL;
					end
				endcase
			end
			ST_EMIT: begin
				if (out_free) begin
					emit = 1'b1;
					res_d.packet_id  = rd_pid;
					res_d.connection = rd_conn;
					res_d.retry_count = rd_rty;
					clr_en = 1'b1;
					res_d.kind = K_FLUSHED;
					if (act_q == ACT_TICK) begin
						if (rd_rty >= maxrty_q) begin
							res_d.kind = K_EXPIRED;
						end else begin
							clr_en = 1'b0;
							res_d.kind = K_RESEND;
							res_d.retry_count = rd_rty + 4'd1;
							wr_en  = 1'b1;
							wr_rty = rd_rty + 4'd1;
						end
					end
					state_d = last_idx ? ST_FINAL : ST_READ;
				end
			end
			ST_FINAL: begin
				if (act_q == ACT_SEND || act_q == ACT_REPLY) begin
					if (!phase2_q) begin
						// read matched slot for reply
						do_read = 1'b1;
					end else if (out_free) begin
						emit = 1'b1;
						res_d.last = 1'b1;
						res_d.packet_id = pid_q;
						state_d = ST_IDLE;
						if (act_q == ACT_SEND) begin
							res_d.connection = conn_q;
							if (found_q || free_found_q) begin
								res_d.kind = K_TRANSMIT;
								wr_en   = 1'b1;
								wr_full = 1'b1;
								wr_idx  = found_q ? slot_q : free_q;
								set_en  = 1'b1;
							end else res_d.kind = K_FULL;
						end else if (!found_q) begin
							res_d.kind = K_IGNORED;
						end else begin
							res_d.connection  = rd_conn;
							res_d.retry_count = rd_rty;
							if (stat_q == rd_exp) begin
								res_d.kind = K_DONE;
								clr_en = 1'b1;
							end else if (stat_q == errstat_q) begin
								res_d.kind = K_FAILED;
								clr_en = 1'b1;
							end else res_d.kind = K_IGNORED;
							wr_idx = slot_q;
						end
					end
				end else if (out_free) begin
					state_d = ST_IDLE;
					if (!any_q) begin
						emit = 1'b1;
						res_d.kind = K_NOTHING;
						res_d.last = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		push_last = (state_q == ST_FINAL) && out_free && any_q
			&& act_q != ACT_SEND && act_q != ACT_REPLY;
		load_out  = 1'b0;
		out_d     = res_d;
		if (emit) begin
			if (state_q == ST_EMIT) begin
				load_out = hold_v_q;
				out_d    = hold_q;
			end else load_out = 1'b1;
		end else if (push_last) begin
			load_out   = 1'b1;
			out_d      = hold_q;
			out_d.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_q  <= '0;
			ovalid_q <= 1'b0;
			hold_v_q <= 1'b0;
			idx_q    <= '0;
			found_q  <= 1'b0;
			free_found_q <= 1'b0;
			phase2_q <= 1'b0;
			any_q    <= 1'b0;
			rd_valid <= 1'b0;
			timed_q  <= 1'b0;
			slot_q   <= '0;
			free_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) ovalid_q <= 1'b1;
			else if (m_tvalid && m_tready) ovalid_q <= 1'b0;
			if (s_acc) begin
				act_q  <= action_t'(s_tuser);
				pid_q  <= s_tdata[31:0];
				conn_q <= s_tdata[39:32];
				stat_q <= s_tdata[43:40];
				now_q  <= s_tdata[75:44];
				idx_q  <= '0;
				found_q <= 1'b0;
				free_found_q <= 1'b0;
				phase2_q <= 1'b0;
				any_q <= 1'b0;
			end
			if (do_read) rd_valid <= valid_q[ridx];
			if (state_q == ST_EVAL) timed_q <= age > timeout_q;
			if (state_q == ST_DECIDE) begin
				if (act_q == ACT_SEND || act_q == ACT_REPLY) begin
					if (rd_valid && rd_pid == pid_q && !found_q) begin
						found_q <= 1'b1;
						slot_q  <= ridx;
					end
					if (!rd_valid && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q <= ridx;
					end
				end
				if (state_d == ST_READ) idx_q <= idx_q + CW'(1);
			end
			if (state_q == ST_EMIT && emit) begin
				if (!last_idx) idx_q <= idx_q + CW'(1);
			end
			if (state_q == ST_FINAL && !phase2_q) phase2_q <= 1'b1;
			if (clr_en) valid_q[wr_idx] <= 1'b0;
			if (set_en) valid_q[wr_idx] <= 1'b1;
			if (emit && state_q == ST_EMIT) begin
				any_q    <= 1'b1;
				hold_q   <= res_d;
				hold_v_q <= 1'b1;
			end else if (push_last) hold_v_q <= 1'b0;
			if (load_out) res_q <= out_d;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {4'd0, res_q.retry_count, res_q.connection, res_q.packet_id};
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last;

endmodule

@@ design/rtrt_checker.sv @@
// Checker: port-level properties of the request timeout retry table.
module rtrt_checker
	import rtrt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [3:0] m_tuser,
	input logic       m_tlast
);

	property p_hold;
		@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser);
	endproperty
	a_hold: assert property (p_hold) else $error("result dropped under stall");

	property p_nothing_last;
		@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == K_NOTHING |-> m_tlast;
	endproperty
	a_nothing: assert property (p_nothing_last) else $error("nothing result not last");

	property p_busy;
		@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready;
	endproperty
	a_busy: assert property (p_busy) else $error("accepted while busy");

endmodule

bind request_timeout_retry_table rtrt_checker u_rtrt_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

@@ tb/sv/rtrt_checker.sv @@
// Checker: predicts request table results from observed input transactions and compares them.
module rtrt_scoreboard
	import rtrt_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic [3:0]  m_tuser,
	input  logic        m_tlast,
	output int          errors,
	output int          pending,
	output int          seen
);
	logic [31:0] tmo;
	logic [3:0]  mrt;
	logic [3:0]  est;
	logic        vld  [DEPTH];
	logic [31:0] pid  [DEPTH];
	logic [7:0]  conn [DEPTH];
	logic [3:0]  exps [DEPTH];
	logic [31:0] tsent[DEPTH];
	logic [3:0]  rty  [DEPTH];
	result_t     expected_results[$];

	task automatic report(input string msg);
		$display("mismatch @%0t: %s", $time, msg);
		errors++;
	endtask

	function automatic result_t mk(kind_t k, logic [31:0] p, logic [7:0] c, logic [3:0] r);
		result_t x;
		x.kind = k; x.packet_id = p; x.connection = c; x.retry_count = r; x.last = 0;
		return x;
	endfunction

	task automatic predict(input logic [1:0] act, input logic [79:0] d);
		logic [31:0] p;
		logic [7:0]  c;
		logic [3:0]  s;
		logic [31:0] now;
		result_t     q[$];
		int          slot;
		p = d[31:0]; c = d[39:32]; s = d[43:40]; now = d[75:44];
		slot = -1;
		if (act == ACT_SEND || act == ACT_REPLY) begin
			for (int i = 0; i < DEPTH; i++)
				if (slot < 0 && vld[i] && pid[i] == p) slot = i;
		end
		case (act)
			ACT_SEND: begin
				if (slot < 0)
					for (int i = 0; i < DEPTH; i++)
						if (slot < 0 && !vld[i]) slot = i;
				if (slot < 0) q.push_back(mk(K_FULL, p, c, 0));
				else begin
					vld[slot] = 1; pid[slot] = p; conn[slot] = c; exps[slot] = s;
					tsent[slot] = now; rty[slot] = 0;
					q.push_back(mk(K_TRANSMIT, p, c, 0));
				end
			end
			ACT_REPLY: begin
				if (slot < 0) q.push_back(mk(K_IGNORED, p, 0, 0));
				else if (s == exps[slot]) begin
					vld[slot] = 0; q.push_back(mk(K_DONE, p, conn[slot], rty[slot]));
				end else if (s == est) begin
					vld[slot] = 0; q.push_back(mk(K_FAILED, p, conn[slot], rty[slot]));
				end else q.push_back(mk(K_IGNORED, p, conn[slot], rty[slot]));
			end
			ACT_TICK: begin
				for (int i = 0; i < DEPTH; i++)
					if (vld[i] && (now - tsent[i]) > tmo) begin
						if (rty[i] >= mrt) begin
							vld[i] = 0; q.push_back(mk(K_EXPIRED, pid[i], conn[i], rty[i]));
						end else begin
							rty[i] = rty[i] + 4'd1; tsent[i] = now;
							q.push_back(mk(K_RESEND, pid[i], conn[i], rty[i]));
						end
					end
			end
			default: begin
				for (int i = 0; i < DEPTH; i++)
					if (vld[i] && conn[i] == c) begin
						vld[i] = 0; q.push_back(mk(K_FLUSHED, pid[i], conn[i], rty[i]));
					end
			end
		endcase
		if (q.size() == 0) q.push_back(mk(K_NOTHING, 0, 0, 0));
		q[q.size()-1].last = 1;
		foreach (q[i]) expected_results.push_back(q[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmo = 1000; mrt = 3; est = 15; errors = 0; seen = 0;
			for (int i = 0; i < DEPTH; i++) vld[i] = 0;
			expected_results.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TIMEOUT: tmo = cfg_data;
					REG_MAXRTY:  mrt = cfg_data[3:0];
					REG_ERRSTAT: est = cfg_data[3:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				result_t e;
				seen++;
				if (expected_results.size() == 0)
					report($sformatf("unexpected result kind %0d", m_tuser));
				else begin
					e = expected_results.pop_front();
					if (m_tuser != e.kind)
						report($sformatf("kind %0d want %0d", m_tuser, e.kind));
					if (m_tdata[31:0] != e.packet_id)
						report($sformatf("packet id %h want %h", m_tdata[31:0], e.packet_id));
					if (m_tdata[39:32] != e.connection)
						report($sformatf("conn %0d want %0d", m_tdata[39:32], e.connection));
					if (m_tdata[43:40] != e.retry_count)
						report($sformatf("retry %0d want %0d", m_tdata[43:40], e.retry_count));
					if (m_tdata[47:44] != 0)
						report("nonzero padding");
					if (m_tlast != e.last)
						report($sformatf("last %0d want %0d", m_tlast, e.last));
				end
			end
			if (s_tvalid && s_tready) predict(s_tuser, s_tdata);
			pending = expected_results.size();
		end
	end
endmodule

@@ tb/sv/tb_request_timeout_retry_table.sv @@
// Testbench top: drives stimulus and configuration into the request table and reports the verdict.
module tb_request_timeout_retry_table;
	import rtrt_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = 0;
	logic [31:0] cfg_data = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [79:0] s_tdata = 0;
	logic [1:0]  s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;
	int          errors, pending, seen;
	int          cycles = 0;
	int          send_idle = 0;
	int          recv_stall = 0;
	int          hold_off = 0;
	int          n_items = 0;
	logic [31:0] ids[8];
	logic [7:0]  conns[4];
	logic [31:0] clock_now = 0;

	localparam int LIMIT = 400000;

	always #5 clk = ~clk;

	request_timeout_retry_table uut (.*);

	rtrt_scoreboard chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout");
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 0;
		end else
			m_tready <= ($urandom_range(99) >= recv_stall);
	end

	task automatic send_item(input logic [1:0] act, input logic [31:0] p, input logic [7:0] c,
			input logic [3:0] s, input logic [31:0] now);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= act;
		s_tdata <= {4'b0, now, s, c, p};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_items++;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [31:0] t, input logic [3:0] m, input logic [3:0] e);
		cfg_we <= 1; cfg_index <= REG_TIMEOUT; cfg_data <= t;
		@(posedge clk);
		cfg_index <= REG_MAXRTY; cfg_data <= {28'd0, m};
		@(posedge clk);
		cfg_index <= REG_ERRSTAT; cfg_data <= {28'd0, e};
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_item();
		int r;
		logic [31:0] p;
		r = $urandom_range(99);
		p = ($urandom_range(9) == 0) ? $urandom : ids[$urandom_range(7)];
		clock_now = clock_now + $urandom_range(40);
		if ($urandom_range(19) == 0) clock_now = $urandom;
		if (r < 40)
			send_item(ACT_SEND, p, conns[$urandom_range(3)], 4'($urandom_range(15)),
				clock_now);
		else if (r < 70)
			send_item(ACT_REPLY, p, 8'($urandom), 4'($urandom_range(15)), clock_now);
		else if (r < 90)
			send_item(ACT_TICK, $urandom, 8'($urandom), 4'($urandom), clock_now);
		else
			send_item(ACT_CLOSE, $urandom, ($urandom_range(3) == 0) ? 8'($urandom)
				: conns[$urandom_range(3)], 4'($urandom), clock_now);
	endtask

	initial begin
		foreach (ids[i]) ids[i] = $urandom;
		ids[0] = 32'h0; ids[1] = 32'hFFFF_FFFF;
		conns[0] = 8'h00; conns[1] = 8'hFF; conns[2] = 8'($urandom); conns[3] = 8'($urandom);
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: fill, overflow, replies, ticks, close, wrapping age
		for (int i = 0; i < 16; i++)
			send_item(ACT_SEND, 32'h100 + i, (i < 8) ? 8'hFF : 8'h00, 4'(i), 32'hFFFF_FFF0);
		send_item(ACT_SEND, 32'hFFFF_FFFF, 8'hAA, 4'hF, 0);
		send_item(ACT_SEND, 32'h101, 8'h55, 4'h3, 32'hFFFF_FFF0);
		send_item(ACT_REPLY, 32'h100, 0, 4'h0, 0);
		send_item(ACT_REPLY, 32'h102, 0, 4'hF, 0);
		send_item(ACT_REPLY, 32'h103, 0, 4'h7, 0);
		send_item(ACT_REPLY, 32'h10F, 0, 4'hF, 0);
		send_item(ACT_REPLY, 32'hDEAD, 0, 4'h1, 0);
		send_item(ACT_TICK, 0, 0, 0, 32'h0000_0100);
		send_item(ACT_TICK, 0, 0, 0, 32'h0000_03E0);
		send_item(ACT_TICK, 0, 0, 0, 32'hFFFF_FFFF);
		send_item(ACT_CLOSE, 0, 8'hFF, 0, 0);
		send_item(ACT_CLOSE, 0, 8'h77, 0, 0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_cfg(0, 0, 0);
				1: write_cfg(32'hFFFF_FFFF, 4'd15, 4'd15);
				default: write_cfg($urandom_range(60), 4'($urandom_range(15)),
					4'($urandom_range(15)));
			endcase
			send_idle = (ph == 2 || ph == 5) ? 71 : (ph == 4 ? 23 : 0);
			recv_stall = (ph == 3) ? 71 : (ph == 4 ? 23 : 0);
			if (ph == 1) hold_off = 400;
			for (int k = 0; k < 12; k++) random_item();
			drain();
		end
		$display("covered %0d input transactions and %0d results over 7 register settings",
			n_items, seen);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

@@ filelist.f @@
design/rtrt_pkg.sv
design/request_timeout_retry_table.sv
design/rtrt_checker.sv
tb/sv/rtrt_checker.sv
tb/sv/tb_request_timeout_retry_table.sv
